### hdl/matrix_multiply_engine_macros.svh
// Assertion macros shared by the matrix multiply engine modules.
// Each macro checks a property at the rising clock edge and is held off during reset.
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// The antecedent implies the consequent in the same cycle.
`define MME_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mme assertion failed");

// The antecedent implies the consequent in the next cycle.
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mme assertion failed");

`else

`define MME_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define MME_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/mme_pkg.sv
package mme_pkg;

   // Sizes of the matrix stores and of the arithmetic.
   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int IDX_W     = 3;
   localparam int CFG_W     = 4;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + $clog2(MAX_DIM);
   localparam int MUL_AW    = IDX_W + CFG_W;

   // Command codes of an input item.
   localparam logic [1:0] CMD_WRITE_A = 2'd0;
   localparam logic [1:0] CMD_WRITE_B = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_A_ROWS     = 2'd0;
   localparam logic [1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [1:0] CSR_B_COLS     = 2'd2;

   // Saturation limits of a result element.
   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Current matrix dimensions.
   typedef struct packed {
      logic [CFG_W-1:0] a_rows;
      logic [CFG_W-1:0] inner_size;
      logic [CFG_W-1:0] b_cols;
   } dims_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             wr_a;
      logic             wr_b;
      logic             issue;
      logic             first;
      logic             last_k;
      logic             last_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [IDX_W-1:0] k;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      dims_type dims;
      logic     result_loaded;
   } dp_status_type;

   // A dimension of zero counts as one, and one above the maximum counts as the maximum.
   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] value);
      logic [CFG_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = CFG_W'(1);
      end else if (value > CFG_W'(MAX_DIM)) begin
         result = CFG_W'(MAX_DIM);
      end
      return result;
   endfunction

endpackage

### hdl/mme_req_if.sv
// Input item channel: element writes and compute commands.
interface mme_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        cmd;
   logic [mme_pkg::IDX_W-1:0]         row_index;
   logic [mme_pkg::IDX_W-1:0]         col_index;
   logic signed [mme_pkg::DATA_W-1:0] element_value;

   modport source (output valid, output cmd, output row_index, output col_index,
                   output element_value, input ready);
   modport sink (input valid, input cmd, input row_index, input col_index,
                 input element_value, output ready);
endinterface

### hdl/mme_rsp_if.sv
// Result item channel: one item per product element.
interface mme_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mme_pkg::IDX_W-1:0]         out_row;
   logic [mme_pkg::IDX_W-1:0]         out_col;
   logic signed [mme_pkg::DATA_W-1:0] out_value;
   logic                              out_last;

   modport source (output valid, output out_row, output out_col, output out_value,
                   output out_last, input ready);
   modport sink (input valid, input out_row, input out_col, input out_value,
                 input out_last, output ready);
endinterface

### hdl/mme_ctrl.sv
`include "matrix_multiply_engine_macros.svh"

module mme_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_cmd,
   output logic                  req_ready,
   input  mme_pkg::dp_status_type status,
   output mme_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT
   } state_type;

   localparam logic [mme_pkg::IDX_W-1:0] IDX_ONE = mme_pkg::IDX_W'(1);

   state_type                   state_ff;
   logic [mme_pkg::IDX_W-1:0]   row_ff;
   logic [mme_pkg::IDX_W-1:0]   col_ff;
   logic [mme_pkg::IDX_W-1:0]   k_ff;
   logic                        accept;
   logic                        k_last;
   logic                        row_last;
   logic                        col_last;

   // Items are taken only between products.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Ends of the three loop counters.
   assign k_last   = (mme_pkg::CFG_W'(k_ff) + mme_pkg::CFG_W'(1)) == status.dims.inner_size;
   assign row_last = (mme_pkg::CFG_W'(row_ff) + mme_pkg::CFG_W'(1)) == status.dims.a_rows;
   assign col_last = (mme_pkg::CFG_W'(col_ff) + mme_pkg::CFG_W'(1)) == status.dims.b_cols;

   // Commands to the datapath.
   always_comb begin
      cmd.wr_a      = accept && (req_cmd == mme_pkg::CMD_WRITE_A);
      cmd.wr_b      = accept && (req_cmd == mme_pkg::CMD_WRITE_B);
      cmd.issue     = (state_ff == ST_RUN);
      cmd.first     = (k_ff == '0);
      cmd.last_k    = k_last;
      cmd.last_elem = row_last && col_last;
      cmd.row       = row_ff;
      cmd.col       = col_ff;
      cmd.k         = k_ff;
   end

   // Sequencer over result rows, result columns and the inner index.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         k_ff     <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && (req_cmd == mme_pkg::CMD_COMPUTE)) begin
                  row_ff   <= '0;
                  col_ff   <= '0;
                  k_ff     <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (k_last) begin
                  state_ff <= ST_WAIT;
               end else begin
                  k_ff <= k_ff + IDX_ONE;
               end
            end
            ST_WAIT: begin
               if (status.result_loaded) begin
                  k_ff <= '0;
                  if (row_last && col_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_RUN;
                     if (col_last) begin
                        col_ff <= '0;
                        row_ff <= row_ff + IDX_ONE;
                     end else begin
                        col_ff <= col_ff + IDX_ONE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A result only leaves the pipeline while the sequencer waits for it.
   `MME_ASSERT_IMPLY(a_load_in_wait, clock, reset, status.result_loaded, state_ff == ST_WAIT)
   // The last inner step of an element hands over to the wait for its result.
   `MME_ASSERT_NEXT(a_run_to_wait, clock, reset, cmd.issue && cmd.last_k, state_ff == ST_WAIT)
   // A compute command starts at the first inner step.
   `MME_ASSERT_NEXT(a_start, clock, reset, accept && (req_cmd == mme_pkg::CMD_COMPUTE), cmd.issue && cmd.first)

endmodule

### hdl/mme_dp.sv
`include "matrix_multiply_engine_macros.svh"

module mme_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [mme_pkg::IDX_W-1:0]         req_row_index,
   input  logic [mme_pkg::IDX_W-1:0]         req_col_index,
   input  logic signed [mme_pkg::DATA_W-1:0] req_element_value,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [mme_pkg::CFG_W-1:0]         csr_wdata,
   input  mme_pkg::ctrl_cmd_type              cmd,
   output mme_pkg::dp_status_type             status,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mme_pkg::IDX_W-1:0]         rsp_out_row,
   output logic [mme_pkg::IDX_W-1:0]         rsp_out_col,
   output logic signed [mme_pkg::DATA_W-1:0] rsp_out_value,
   output logic                              rsp_out_last
);

   mme_pkg::dims_type                 dims_ff;

   logic [mme_pkg::DATA_W-1:0]        mem_a [mme_pkg::DEPTH];
   logic [mme_pkg::DATA_W-1:0]        mem_b [mme_pkg::DEPTH];
   logic [mme_pkg::MUL_AW-1:0]        wa_a_full;
   logic [mme_pkg::MUL_AW-1:0]        wa_b_full;
   logic [mme_pkg::MUL_AW-1:0]        ra_a_full;
   logic [mme_pkg::MUL_AW-1:0]        ra_b_full;
   logic                              wr_a_en;
   logic                              wr_b_en;

   logic signed [mme_pkg::DATA_W-1:0] a_rd_ff;
   logic signed [mme_pkg::DATA_W-1:0] b_rd_ff;
   logic                              s1_valid_ff;
   logic                              s1_first_ff;
   logic                              s1_lastk_ff;
   logic                              s1_last_ff;
   logic [mme_pkg::IDX_W-1:0]         s1_row_ff;
   logic [mme_pkg::IDX_W-1:0]         s1_col_ff;

   logic signed [mme_pkg::PROD_W-1:0] prod_ff;
   logic                              s2_valid_ff;
   logic                              s2_first_ff;
   logic                              s2_lastk_ff;
   logic                              s2_last_ff;
   logic [mme_pkg::IDX_W-1:0]         s2_row_ff;
   logic [mme_pkg::IDX_W-1:0]         s2_col_ff;

   logic signed [mme_pkg::ACC_W-1:0]  acc_ff;
   logic signed [mme_pkg::ACC_W-1:0]  acc_in;
   logic                              done_ff;
   logic                              res_last_ff;
   logic [mme_pkg::IDX_W-1:0]         res_row_ff;
   logic [mme_pkg::IDX_W-1:0]         res_col_ff;

   logic signed [mme_pkg::ACC_W-1:0]  shifted;
   logic [mme_pkg::ACC_W-mme_pkg::DATA_W:0] upper;
   logic [mme_pkg::DATA_W-1:0]        sat_value;
   logic                              load;

   logic                              rsp_valid_ff;
   logic [mme_pkg::IDX_W-1:0]         out_row_ff;
   logic [mme_pkg::IDX_W-1:0]         out_col_ff;
   logic signed [mme_pkg::DATA_W-1:0] out_value_ff;
   logic                              out_last_ff;

   // Dimension registers, clamped as they are written.
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff.a_rows     <= mme_pkg::CFG_W'(1);
         dims_ff.inner_size <= mme_pkg::CFG_W'(1);
         dims_ff.b_cols     <= mme_pkg::CFG_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            mme_pkg::CSR_A_ROWS:     dims_ff.a_rows     <= mme_pkg::clamp_dim(csr_wdata);
            mme_pkg::CSR_INNER_SIZE: dims_ff.inner_size <= mme_pkg::clamp_dim(csr_wdata);
            mme_pkg::CSR_B_COLS:     dims_ff.b_cols     <= mme_pkg::clamp_dim(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // Row-major write addresses, and the range check that drops stray writes.
   assign wa_a_full = mme_pkg::MUL_AW'(req_row_index) * mme_pkg::MUL_AW'(dims_ff.inner_size)
                      + mme_pkg::MUL_AW'(req_col_index);
   assign wa_b_full = mme_pkg::MUL_AW'(req_row_index) * mme_pkg::MUL_AW'(dims_ff.b_cols)
                      + mme_pkg::MUL_AW'(req_col_index);
   assign wr_a_en = cmd.wr_a
                    && (mme_pkg::CFG_W'(req_row_index) < dims_ff.a_rows)
                    && (mme_pkg::CFG_W'(req_col_index) < dims_ff.inner_size);
   assign wr_b_en = cmd.wr_b
                    && (mme_pkg::CFG_W'(req_row_index) < dims_ff.inner_size)
                    && (mme_pkg::CFG_W'(req_col_index) < dims_ff.b_cols);

   // Read addresses of A[row][k] and B[k][col].
   assign ra_a_full = mme_pkg::MUL_AW'(cmd.row) * mme_pkg::MUL_AW'(dims_ff.inner_size)
                      + mme_pkg::MUL_AW'(cmd.k);
   assign ra_b_full = mme_pkg::MUL_AW'(cmd.k) * mme_pkg::MUL_AW'(dims_ff.b_cols)
                      + mme_pkg::MUL_AW'(cmd.col);

   // Matrix stores: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (wr_a_en) begin
         mem_a[wa_a_full[mme_pkg::ADDR_W-1:0]] <= req_element_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_b_en) begin
         mem_b[wa_b_full[mme_pkg::ADDR_W-1:0]] <= req_element_value;
      end
   end

   always_ff @(posedge clock) begin
      a_rd_ff <= mem_a[ra_a_full[mme_pkg::ADDR_W-1:0]];
      b_rd_ff <= mem_b[ra_b_full[mme_pkg::ADDR_W-1:0]];
   end

   // Product register.
   always_ff @(posedge clock) begin
      prod_ff <= a_rd_ff * b_rd_ff;
   end

   // Accumulator: the first product of an element restarts the sum.
   always_comb begin
      if (s2_first_ff) begin
         acc_in = mme_pkg::ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + mme_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   // Tags that travel with each product through the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first;
      s1_lastk_ff <= cmd.last_k;
      s1_last_ff  <= cmd.last_elem;
      s1_row_ff   <= cmd.row;
      s1_col_ff   <= cmd.col;
      s2_first_ff <= s1_first_ff;
      s2_lastk_ff <= s1_lastk_ff;
      s2_last_ff  <= s1_last_ff;
      s2_row_ff   <= s1_row_ff;
      s2_col_ff   <= s1_col_ff;
   end

   // A finished sum waits here until the output register is free.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else if (s2_valid_ff && s2_lastk_ff) begin
         done_ff <= 1'b1;
      end else if (load) begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_lastk_ff) begin
         res_row_ff  <= s2_row_ff;
         res_col_ff  <= s2_col_ff;
         res_last_ff <= s2_last_ff;
      end
   end

   // Drop the fraction bits, rounding down, then saturate to 32 bits.
   assign shifted = acc_ff >>> mme_pkg::FRAC_BITS;
   assign upper   = shifted[mme_pkg::ACC_W-1:mme_pkg::DATA_W-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         sat_value = shifted[mme_pkg::DATA_W-1:0];
      end else if (shifted[mme_pkg::ACC_W-1]) begin
         sat_value = mme_pkg::SAT_MIN;
      end else begin
         sat_value = mme_pkg::SAT_MAX;
      end
   end

   // Output register.
   assign load = done_ff && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_row_ff   <= res_row_ff;
         out_col_ff   <= res_col_ff;
         out_value_ff <= sat_value;
         out_last_ff  <= res_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = out_row_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_out_last  = out_last_ff;

   assign status.dims          = dims_ff;
   assign status.result_loaded = load;

   // Only one element is in flight: a waiting sum has no products behind it.
   `MME_ASSERT_IMPLY(a_single_elem, clock, reset, done_ff, !s1_valid_ff && !s2_valid_ff)
   // No new element starts while a finished sum still waits.
   `MME_ASSERT_IMPLY(a_no_issue_pending, clock, reset, cmd.issue, !done_ff)
   // Store writes never arrive while a product is being computed.
   `MME_ASSERT_IMPLY(a_write_idle, clock, reset, cmd.wr_a || cmd.wr_b, !s1_valid_ff && !s2_valid_ff && !done_ff)

endmodule

### hdl/matrix_multiply_engine.sv
// General matrix multiply engine for signed Q16.16 values. Load A (a_rows x inner_size)
// and B (inner_size x b_cols) one element per item with the write commands, then send a
// compute command: the engine returns every element C[r][c], row by row, with out_last
// on the final one. Each sum of products is kept exactly, shifted right by the fraction
// bits (rounding down) and saturated to 32 bits. Writes outside the current dimensions
// are dropped, and the dimension registers clamp to the range 1 to 8. A compute item
// is not done, and the next item is not taken, until its last result element is loaded
// into the output register: one shared multiply-accumulate unit handles one inner
// step per cycle, and each result element then waits for its sum to pass the store
// read, the product register and the accumulator, and for the output register to be
// free. Reading an element that was never written gives an undefined result.
module matrix_multiply_engine (
   input  logic                        clock,
   input  logic                        reset,
   mme_req_if.sink                     req_ch,
   mme_rsp_if.source                   rsp_ch,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [mme_pkg::CFG_W-1:0]   csr_wdata
);

   mme_pkg::ctrl_cmd_type  ctrl_cmd;
   mme_pkg::dp_status_type dp_status;

   // Loop sequencer.
   mme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // Stores, multiply-accumulate pipeline and output register.
   mme_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_row_index     (req_ch.row_index),
      .req_col_index     (req_ch.col_index),
      .req_element_value (req_ch.element_value),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (ctrl_cmd),
      .status            (dp_status),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_out_row       (rsp_ch.out_row),
      .rsp_out_col       (rsp_ch.out_col),
      .rsp_out_value     (rsp_ch.out_value),
      .rsp_out_last      (rsp_ch.out_last)
   );

endmodule

### verif/tb_matrix_multiply_engine.sv
`timescale 1ns / 1ps

module tb_matrix_multiply_engine;

   localparam int ITEM_TARGET    = 310;
   localparam int QUIET_TAIL     = 40;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 16;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   // Command code that the engine does not use; it must be dropped silently.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Bounds of a shifted sum that still fits in a result element.
   localparam logic signed [71:0] SUM_HI = 72'sh7FFF_FFFF;
   localparam logic signed [71:0] SUM_LO = -72'sh8000_0000;

   typedef enum logic {STEP_ITEM, STEP_CSR} step_kind_type;

   // One row of the directed sequence: an item or a register write.
   typedef struct {
      step_kind_type                kind;
      logic [1:0]                   code;
      logic [mme_pkg::IDX_W-1:0]    row;
      logic [mme_pkg::IDX_W-1:0]    col;
      logic [mme_pkg::DATA_W-1:0]   value;
      bit                           fixed;
      logic [mme_pkg::DATA_W-1:0]   answer;
   } directed_row_type;

   // One expected element of a product.
   typedef struct {
      logic [mme_pkg::IDX_W-1:0]    row;
      logic [mme_pkg::IDX_W-1:0]    col;
      logic [mme_pkg::DATA_W-1:0]   value;
      logic                         last;
   } product_elem_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_we = 1'b0;
   logic [1:0]                  csr_index = '0;
   logic [mme_pkg::CFG_W-1:0]   csr_wdata = '0;

   mme_req_if req_if();
   mme_rsp_if rsp_if();

   matrix_multiply_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the operand stores, their written entries and the dimensions.
   logic [mme_pkg::DATA_W-1:0] a_words [mme_pkg::DEPTH];
   logic [mme_pkg::DATA_W-1:0] b_words [mme_pkg::DEPTH];
   bit [mme_pkg::DEPTH-1:0]    a_loaded = '0;
   bit [mme_pkg::DEPTH-1:0]    b_loaded = '0;
   int                         dim_rows = 1;
   int                         dim_inner = 1;
   int                         dim_cols = 1;

   product_elem_type pending_elems [$];
   int               mismatch_count = 0;
   int               sent_items = 0;
   int               idle_cycles = 0;
   bit               quiet_tail = 1'b0;
   bit               hold_armed = 1'b0;
   bit               hold_done = 1'b0;

   // Extremes of the values and of the dimension codes, then the clamped
   // dimensions with a tall A whose elements pass through a unit B.
   directed_row_type directed_rows [28] = '{
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd0, 3'd0, 32'h0001_0000, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_B, 3'd0, 3'd0, 32'h0001_0000, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h0001_0000},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd7, 3'd7, 32'hDEAD_BEEF, 1'b0, 32'h0},
      '{STEP_ITEM, CMD_UNUSED,           3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h0001_0000},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_B, 3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, mme_pkg::SAT_MAX},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, mme_pkg::SAT_MIN},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_B, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, mme_pkg::SAT_MAX},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_B, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'hFFFF_FFFF},
      '{STEP_CSR,  mme_pkg::CSR_A_ROWS,     3'd0, 3'd0, 32'd15, 1'b0, 32'h0},
      '{STEP_CSR,  mme_pkg::CSR_INNER_SIZE, 3'd0, 3'd0, 32'd0,  1'b0, 32'h0},
      '{STEP_CSR,  mme_pkg::CSR_B_COLS,     3'd0, 3'd0, 32'd0,  1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_B, 3'd0, 3'd0, 32'h0001_0000, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd1, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd2, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd3, 3'd0, 32'h0000_0001, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd4, 3'd0, 32'hFFFF_0000, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd5, 3'd0, 32'h0003_8000, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd6, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_WRITE_A, 3'd7, 3'd0, 32'h1234_5678, 1'b0, 32'h0},
      '{STEP_ITEM, mme_pkg::CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b0, 32'h0}
   };

   // A dimension code of zero means one, and codes above the maximum mean the maximum.
   function automatic int fit_dim(input logic [mme_pkg::CFG_W-1:0] code);
      if (code == '0) begin
         return 1;
      end
      if (code > mme_pkg::CFG_W'(mme_pkg::MAX_DIM)) begin
         return mme_pkg::MAX_DIM;
      end
      return int'(code);
   endfunction

   // Exact sum of products, shifted down with truncation toward minus infinity and
   // saturated to the width of a result element.
   function automatic logic [mme_pkg::DATA_W-1:0] dot_product(input int r, input int c);
      logic signed [71:0] acc;
      logic signed [63:0] term;
      logic signed [71:0] shifted;
      acc = '0;
      for (int k = 0; k < dim_inner; k++) begin
         term = $signed(a_words[r * dim_inner + k]) * $signed(b_words[k * dim_cols + c]);
         acc = acc + term;
      end
      shifted = acc >>> mme_pkg::FRAC_BITS;
      if (shifted > SUM_HI) begin
         return mme_pkg::SAT_MAX;
      end
      if (shifted < SUM_LO) begin
         return mme_pkg::SAT_MIN;
      end
      return shifted[mme_pkg::DATA_W-1:0];
   endfunction

   // Track the effect of one accepted item and queue the product elements it causes.
   task automatic model_item(input logic [1:0] cmd,
                             input logic [mme_pkg::IDX_W-1:0] row,
                             input logic [mme_pkg::IDX_W-1:0] col,
                             input logic [mme_pkg::DATA_W-1:0] value,
                             input bit fixed,
                             input logic [mme_pkg::DATA_W-1:0] answer);
      product_elem_type elem;
      int               addr;
      case (cmd)
         mme_pkg::CMD_WRITE_A: begin
            if (row < dim_rows && col < dim_inner) begin
               addr = row * dim_inner + col;
               a_words[addr] = value;
               a_loaded[addr] = 1'b1;
            end
         end
         mme_pkg::CMD_WRITE_B: begin
            if (row < dim_inner && col < dim_cols) begin
               addr = row * dim_cols + col;
               b_words[addr] = value;
               b_loaded[addr] = 1'b1;
            end
         end
         mme_pkg::CMD_COMPUTE: begin
            if (fixed) begin
               elem = '{row: '0, col: '0, value: answer, last: 1'b1};
               pending_elems.push_back(elem);
            end else begin
               for (int r = 0; r < dim_rows; r++) begin
                  for (int c = 0; c < dim_cols; c++) begin
                     elem.row = mme_pkg::IDX_W'(r);
                     elem.col = mme_pkg::IDX_W'(c);
                     elem.value = dot_product(r, c);
                     elem.last = (r == dim_rows - 1) && (c == dim_cols - 1);
                     pending_elems.push_back(elem);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic flag_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Offer one item, sometimes after a gap, and hold it until the engine takes it.
   task automatic send_item(input logic [1:0] cmd,
                            input logic [mme_pkg::IDX_W-1:0] row,
                            input logic [mme_pkg::IDX_W-1:0] col,
                            input logic [mme_pkg::DATA_W-1:0] value,
                            input bit fixed = 1'b0,
                            input logic [mme_pkg::DATA_W-1:0] answer = '0);
      int gap;
      @(negedge clock);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd <= cmd;
      req_if.row_index <= row;
      req_if.col_index <= col;
      req_if.element_value <= value;
      do begin
         @(posedge clock);
      end while (req_if.ready !== 1'b1);
      model_item(cmd, row, col, value, fixed, answer);
      sent_items++;
      quiet_tail = (sent_items >= ITEM_TARGET - QUIET_TAIL);
   endtask

   // Stop offering items and wait until the engine has delivered everything.
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_elems.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [mme_pkg::CFG_W-1:0] data);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      case (index)
         mme_pkg::CSR_A_ROWS:     dim_rows = fit_dim(data);
         mme_pkg::CSR_INNER_SIZE: dim_inner = fit_dim(data);
         mme_pkg::CSR_B_COLS:     dim_cols = fit_dim(data);
         default: begin
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Element values lean toward the saturation limits and small fixed-point numbers.
   function automatic logic [mme_pkg::DATA_W-1:0] pick_element();
      case ($urandom_range(0, 7))
         0: return mme_pkg::SAT_MAX;
         1: return mme_pkg::SAT_MIN;
         2: return mme_pkg::DATA_W'($urandom_range(0, 32'h7_FFFF))
                   - mme_pkg::DATA_W'(32'h4_0000);
         3: return mme_pkg::DATA_W'($urandom_range(0, 3)) - mme_pkg::DATA_W'(1);
         default: return mme_pkg::DATA_W'($urandom);
      endcase
   endfunction

   // Mostly small dimensions, sometimes a code that clamps.
   function automatic logic [mme_pkg::CFG_W-1:0] pick_dim_code();
      case ($urandom_range(0, 11))
         0: return '0;
         1: return mme_pkg::CFG_W'($urandom_range(9, 15));
         default: return mme_pkg::CFG_W'($urandom_range(1, 4));
      endcase
   endfunction

   // An item outside the current shapes, or with the unused command.
   task automatic send_noise();
      logic [1:0] cmd;
      case ($urandom_range(0, 2))
         0: cmd = mme_pkg::CMD_WRITE_A;
         1: cmd = mme_pkg::CMD_WRITE_B;
         default: cmd = CMD_UNUSED;
      endcase
      send_item(cmd, mme_pkg::IDX_W'($urandom_range(0, 7)),
                mme_pkg::IDX_W'($urandom_range(0, 7)), mme_pkg::DATA_W'($urandom));
   endtask

   // Load every operand entry that the current shapes read and that is still
   // unwritten, and rewrite some of the others.
   task automatic load_operands();
      int addr;
      for (int r = 0; r < dim_rows; r++) begin
         for (int k = 0; k < dim_inner; k++) begin
            addr = r * dim_inner + k;
            if ($urandom_range(0, 7) == 0) begin
               send_noise();
            end
            if (!a_loaded[addr] || $urandom_range(0, 3) == 0) begin
               send_item(mme_pkg::CMD_WRITE_A, mme_pkg::IDX_W'(r), mme_pkg::IDX_W'(k),
                         pick_element());
            end
         end
      end
      for (int k = 0; k < dim_inner; k++) begin
         for (int c = 0; c < dim_cols; c++) begin
            addr = k * dim_cols + c;
            if ($urandom_range(0, 7) == 0) begin
               send_noise();
            end
            if (!b_loaded[addr] || $urandom_range(0, 3) == 0) begin
               send_item(mme_pkg::CMD_WRITE_B, mme_pkg::IDX_W'(k), mme_pkg::IDX_W'(c),
                         pick_element());
            end
         end
      end
   endtask

   // Rewrite a few entries inside the current shapes.
   task automatic touch_operands();
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 1) == 0) begin
            send_item(mme_pkg::CMD_WRITE_A,
                      mme_pkg::IDX_W'($urandom_range(0, dim_rows - 1)),
                      mme_pkg::IDX_W'($urandom_range(0, dim_inner - 1)), pick_element());
         end else begin
            send_item(mme_pkg::CMD_WRITE_B,
                      mme_pkg::IDX_W'($urandom_range(0, dim_inner - 1)),
                      mme_pkg::IDX_W'($urandom_range(0, dim_cols - 1)), pick_element());
         end
      end
   endtask

   // Result side: random stalls, one long hold-off when asked for, none at the end.
   initial begin
      int burst;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_armed && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_done = 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
            burst = $urandom_range(1, 19);
            rsp_if.ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Compare each delivered element with the oldest one expected.
   always @(posedge clock) begin
      product_elem_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_elems.size() == 0) begin
            flag_mismatch($sformatf("element (%0d,%0d) = %h with nothing expected",
                                    rsp_if.out_row, rsp_if.out_col, rsp_if.out_value));
         end else begin
            want = pending_elems.pop_front();
            if (rsp_if.out_row !== want.row) begin
               flag_mismatch($sformatf("row %0d, expected %0d", rsp_if.out_row, want.row));
            end
            if (rsp_if.out_col !== want.col) begin
               flag_mismatch($sformatf("col %0d, expected %0d", rsp_if.out_col, want.col));
            end
            if (rsp_if.out_value !== want.value) begin
               flag_mismatch($sformatf("value of (%0d,%0d) %h, expected %h",
                                       want.row, want.col, rsp_if.out_value, want.value));
            end
            if (rsp_if.out_last !== want.last) begin
               flag_mismatch($sformatf("last of (%0d,%0d) %b, expected %b",
                                       want.row, want.col, rsp_if.out_last, want.last));
            end
         end
      end
   end

   // End the run when neither side has moved an item for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Stimulus: directed rows first, then phases of random shapes and contents.
   initial begin
      int extra;
      req_if.valid = 1'b0;
      req_if.cmd = mme_pkg::CMD_WRITE_A;
      req_if.row_index = '0;
      req_if.col_index = '0;
      req_if.element_value = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == STEP_CSR) begin
            write_reg(directed_rows[n].code, directed_rows[n].value[mme_pkg::CFG_W-1:0]);
         end else begin
            send_item(directed_rows[n].code, directed_rows[n].row, directed_rows[n].col,
                      directed_rows[n].value, directed_rows[n].fixed,
                      directed_rows[n].answer);
         end
      end

      for (int phase = 0; sent_items < ITEM_TARGET; phase++) begin
         // The second phase uses the largest shapes, reached partly through clamping codes.
         if (phase == 1) begin
            write_reg(mme_pkg::CSR_A_ROWS, mme_pkg::CFG_W'(15));
            write_reg(mme_pkg::CSR_INNER_SIZE, mme_pkg::CFG_W'(8));
            write_reg(mme_pkg::CSR_B_COLS, mme_pkg::CFG_W'(9));
         end else begin
            write_reg(mme_pkg::CSR_A_ROWS, pick_dim_code());
            write_reg(mme_pkg::CSR_INNER_SIZE, pick_dim_code());
            write_reg(mme_pkg::CSR_B_COLS, pick_dim_code());
         end
         load_operands();
         send_item(mme_pkg::CMD_COMPUTE, mme_pkg::IDX_W'($urandom_range(0, 7)),
                   mme_pkg::IDX_W'($urandom_range(0, 7)), mme_pkg::DATA_W'($urandom));
         extra = (phase == 1) ? 0 : $urandom_range(0, 2);
         // Block the result side while more items keep coming, so the engine backs up.
         if (!hold_done && !hold_armed && dim_rows * dim_cols >= 4) begin
            hold_armed = 1'b1;
            if (extra == 0) begin
               extra = 1;
            end
         end
         repeat (extra) begin
            touch_operands();
            send_item(mme_pkg::CMD_COMPUTE, '0, '0, '0);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
